[hdl/sed_pkg.sv]
// sed_pkg: shared constants, types and single-precision float helpers
// for the squared euclidean distance block. No dependencies.
package sed_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int LANES      = 8;
  localparam int HALF_LANES = LANES / 2;
  localparam int LANE_W     = $clog2(LANES);
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int FP_W       = 32;

  localparam logic [FP_W-1:0] QNAN = 32'h7FC0_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMENSION  = 2'd0,
    CFG_BLOCK_MODE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              last;
    logic              fold_before;
    logic              fold_after;
    logic              to_tail;
    logic [LANE_W-1:0] lane;
  } route_t;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [FP_W-1:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [FP_W-1:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [FP_W-1:0] canon_nan(input logic [FP_W-1:0] x);
    return is_nan(x) ? QNAN : x;
  endfunction

  // round to nearest even, subnormals kept
  function automatic logic [FP_W-1:0] fp_add(input logic [FP_W-1:0] x,
                                              input logic [FP_W-1:0] y);
    logic [FP_W-1:0] big, sml, res;
    logic            s1, s2, stk, inc;
    logic [7:0]      e1, e2, d8;
    logic [23:0]     m1, m2;
    logic [26:0]     m1x, m2x, mant27;
    logic [27:0]     sum;
    logic [4:0]      lz;
    logic [9:0]      ee, shamt, ef;
    logic [24:0]     mr;
    res    = '0;
    mant27 = '0;
    ee     = '0;
    if (is_nan(x) || is_nan(y)) begin
      res = QNAN;
    end else if (is_inf(x) && is_inf(y)) begin
      res = (x[31] != y[31]) ? QNAN : x;
    end else if (is_inf(x)) begin
      res = x;
    end else if (is_inf(y)) begin
      res = y;
    end else begin
      if (y[30:0] > x[30:0]) begin
        big = y;
        sml = x;
      end else begin
        big = x;
        sml = y;
      end
      s1  = big[31];
      s2  = sml[31];
      e1  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e2  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      m1  = {big[30:23] != 8'd0, big[22:0]};
      m2  = {sml[30:23] != 8'd0, sml[22:0]};
      d8  = e1 - e2;
      m1x = {m1, 3'b000};
      if (d8 >= 8'd27) begin
        m2x = {26'd0, |m2};
      end else begin
        stk = |({m2, 3'b000} & ~({27{1'b1}} << d8));
        m2x = ({m2, 3'b000} >> d8) | {26'd0, stk};
      end
      if (s1 ^ s2) begin
        sum = {1'b0, m1x} - {1'b0, m2x};
      end else begin
        sum = {1'b0, m1x} + {1'b0, m2x};
      end
      if (sum == 28'd0) begin
        res = {s1 & s2, 31'd0};
      end else begin
        if (sum[27]) begin
          mant27 = {sum[27:2], sum[1] | sum[0]};
          ee     = {2'b00, e1} + 10'd1;
        end else begin
          lz     = lzc27(sum[26:0]);
          shamt  = ({5'd0, lz} < ({2'b00, e1} - 10'd1)) ? {5'd0, lz}
                                                       : ({2'b00, e1} - 10'd1);
          mant27 = sum[26:0] << shamt;
          ee     = {2'b00, e1} - shamt;
        end
        inc = mant27[2] & (mant27[1] | mant27[0] | mant27[3]);
        mr  = {1'b0, mant27[26:3]} + {24'd0, inc};
        if (mr[24]) begin
          ef = ee + 10'd1;
        end else if (mr[23]) begin
          ef = ee;
        end else begin
          ef = 10'd0;
        end
        if (ef >= 10'd255) begin
          res = {s1, 8'hFF, 23'd0};
        end else begin
          res = {s1, ef[7:0], mr[24] ? mr[23:1] : mr[22:0]};
        end
      end
    end
    return res;
  endfunction

  function automatic logic [FP_W-1:0] fp_sub(input logic [FP_W-1:0] x,
                                              input logic [FP_W-1:0] y);
    return fp_add(x, {~y[31], y[30:0]});
  endfunction

  function automatic logic [FP_W-1:0] fp_mul(input logic [FP_W-1:0] x,
                                              input logic [FP_W-1:0] y);
    logic [FP_W-1:0]   res;
    logic              s, stk, inc;
    logic              xz, yz;
    logic [7:0]        ex, ey;
    logic [23:0]       mx, my, mant;
    logic [47:0]       p, pn, q;
    logic [5:0]        lz;
    logic signed [10:0] e, ef_base, ef, rsh;
    logic [24:0]       mr;
    res = '0;
    s   = x[31] ^ y[31];
    xz  = (x[30:0] == 31'd0);
    yz  = (y[30:0] == 31'd0);
    if (is_nan(x) || is_nan(y)) begin
      res = QNAN;
    end else if ((is_inf(x) && yz) || (is_inf(y) && xz)) begin
      res = QNAN;
    end else if (is_inf(x) || is_inf(y)) begin
      res = {s, 8'hFF, 23'd0};
    end else if (xz || yz) begin
      res = {s, 31'd0};
    end else begin
      ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      mx  = {x[30:23] != 8'd0, x[22:0]};
      my  = {y[30:23] != 8'd0, y[22:0]};
      p   = mx * my;
      lz  = lzc48(p);
      pn  = p << lz;
      e   = $signed({3'b000, ex}) + $signed({3'b000, ey}) - 11'sd126
            - $signed({5'd0, lz});
      stk = 1'b0;
      if (e > 11'sd0) begin
        q       = pn;
        ef_base = e;
      end else begin
        rsh     = 11'sd1 - e;
        ef_base = 11'sd1;
        if (rsh >= 11'sd50) begin
          q   = '0;
          stk = 1'b1;
        end else begin
          q   = pn >> rsh[5:0];
          stk = |(pn & ~({48{1'b1}} << rsh[5:0]));
        end
      end
      mant = q[47:24];
      inc  = q[23] & ((|q[22:0]) | stk | mant[0]);
      mr   = {1'b0, mant} + {24'd0, inc};
      if (mr[24]) begin
        ef = ef_base + 11'sd1;
      end else if (mr[23]) begin
        ef = ef_base;
      end else begin
        ef = 11'sd0;
      end
      if (ef >= 11'sd255) begin
        res = {s, 8'hFF, 23'd0};
      end else begin
        res = {s, ef[7:0], mr[24] ? mr[23:1] : mr[22:0]};
      end
    end
    return res;
  endfunction

endpackage

[hdl/sed_if.sv]
// sed_if: valid/ready channel interfaces of the distance block
// (element pairs, distance results, register writes). Uses sed_pkg.
interface sed_elem_if import sed_pkg::*;;
  logic            valid;
  logic            ready;
  logic [FP_W-1:0] elem_a;
  logic [FP_W-1:0] elem_b;
  modport source (output valid, elem_a, elem_b, input ready);
  modport sink   (input valid, elem_a, elem_b, output ready);
endinterface

interface sed_dist_if import sed_pkg::*;;
  logic            valid;
  logic            ready;
  logic [FP_W-1:0] distance_bits;
  modport source (output valid, distance_bits, input ready);
  modport sink   (input valid, distance_bits, output ready);
endinterface

interface sed_cfg_if import sed_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/squared_euclidean_distance.sv]
// squared_euclidean_distance: streaming float32 squared distance of two vectors
// depends on sed_pkg and the channel interfaces in sed_if
//
// elems takes one element pair (elem_a, elem_b) per transfer; after the
// transfer of the last pair of a vector, result gives one distance_bits value.
// cfg writes dimension (index 0) or block_mode (index 1); write only while idle.
// Each write clears the partial sums and the element count. cfg is always ready.
// Pipeline: input register, subtract, square, accumulate into 8 lane sums or
// the tail sum, then a reduction unit with one adder that sums the lanes and the
// tail in order, one add per cycle; the last add waits for a free output register.
// Throughput: one pair per cycle unless the accumulate stage stalls elems. In
// block_mode 1 the lane fold is an extra accumulate step that stalls elems, once
// per vector of 16 or more pairs. A vector ending while the reduction unit still
// works on the previous one waits, so the rate of short vectors is set by the
// reduction adder.
// Reset (rst, synchronous) sets dimension 16, block_mode 0 and empties all
// stages. A stalled result channel holds its distance; the reduction unit then
// waits and the pipeline stops only when the next vector end arrives.
module squared_euclidean_distance import sed_pkg::*; (
  input logic     clk,
  input logic     rst,
  sed_cfg_if.sink cfg,
  sed_elem_if.sink elems,
  sed_dist_if.source result
);

  logic [DIM_W-1:0] dimension;
  logic             block_mode;
  logic [DIM_W-1:0] element_count;
  logic [DIM_W-1:0] eff_dim;
  logic [DIM_W-1:0] q16;
  logic [DIM_W-1:0] q4;
  route_t           route_in;

  logic cfg_wr;
  logic accept;
  logic adv;

  logic            s1_valid;
  logic [FP_W-1:0] s1_a;
  logic [FP_W-1:0] s1_b;
  route_t          s1_route;
  logic            s2_valid;
  logic [FP_W-1:0] s2_diff;
  route_t          s2_route;
  logic            s3_valid;
  logic [FP_W-1:0] s3_sq;
  route_t          s3_route;
  logic            phase;

  logic [FP_W-1:0] lane_sums [LANES];
  logic [FP_W-1:0] tail_sum;
  logic [FP_W-1:0] lane_next [LANES];
  logic [FP_W-1:0] tail_next;
  logic [FP_W-1:0] fold_sum [HALF_LANES];
  logic [FP_W-1:0] acc_operand;
  logic [FP_W-1:0] acc_sum;

  logic two_step;
  logic final_step;
  logic do_fold;
  logic do_acc;
  logic complete;
  logic commit;
  logic handoff;

  logic              red_busy;
  logic [LANE_W:0]   red_k;
  logic [LANE_W:0]   red_last_k;
  logic [FP_W-1:0]   red_acc;
  logic [FP_W-1:0]   red_lanes [LANES];
  logic [FP_W-1:0]   red_tail;
  logic              red_four;
  logic [FP_W-1:0]   red_operand;
  logic [FP_W-1:0]   red_sum;
  logic              out_free;
  logic              red_done;

  logic            out_valid;
  logic [FP_W-1:0] out_data;

  // config port
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension  <= DIM_W'(16);
      block_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg.index)
        CFG_DIMENSION:  dimension  <= cfg.data[DIM_W-1:0];
        CFG_BLOCK_MODE: block_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // routing of the next element
  always_comb begin
    if (dimension == '0) begin
      eff_dim = DIM_W'(1);
    end else if (dimension > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = dimension;
    end
    q16 = {eff_dim[DIM_W-1:4], 4'b0000};
    q4  = {eff_dim[DIM_W-1:2], 2'b00};

    route_in.last        = (element_count == eff_dim - DIM_W'(1));
    route_in.fold_before = block_mode && (element_count == q16) && (q16 != '0);
    route_in.fold_after  = block_mode && route_in.last && (q16 == eff_dim);
    if (element_count < q16) begin
      route_in.to_tail = 1'b0;
      route_in.lane    = element_count[LANE_W-1:0];
    end else if (block_mode && element_count < q4) begin
      route_in.to_tail = 1'b0;
      route_in.lane    = {1'b0, element_count[LANE_W-2:0]};
    end else begin
      route_in.to_tail = 1'b1;
      route_in.lane    = '0;
    end
  end

  assign elems.ready = adv;
  assign accept      = elems.valid && elems.ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      element_count <= '0;
    end else if (accept) begin
      element_count <= route_in.last ? '0 : element_count + DIM_W'(1);
    end
  end

  // subtract and square stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a     <= elems.elem_a;
      s1_b     <= elems.elem_b;
      s1_route <= route_in;
      s2_diff  <= fp_sub(s1_a, s1_b);
      s2_route <= s1_route;
      s3_sq    <= fp_mul(s2_diff, s2_diff);
      s3_route <= s2_route;
    end
  end

  // accumulate stage
  assign two_step   = s3_route.fold_before || s3_route.fold_after;
  assign final_step = s3_valid && (!two_step || phase);
  assign do_fold    = s3_valid && ((s3_route.fold_before && !phase) ||
                                   (s3_route.fold_after && phase));
  assign do_acc     = s3_valid && ((s3_route.fold_before && phase) ||
                                   (s3_route.fold_after && !phase) || !two_step);
  assign complete   = final_step && (!s3_route.last || !red_busy);
  assign commit     = !final_step || complete;
  assign handoff    = complete && s3_route.last;
  assign adv        = !s3_valid || complete;

  assign acc_operand = s3_route.to_tail ? tail_sum : lane_sums[s3_route.lane];
  assign acc_sum     = fp_add(acc_operand, s3_sq);

  always_comb begin
    for (int j = 0; j < HALF_LANES; j++) begin
      fold_sum[j] = fp_add(lane_sums[j], lane_sums[j + HALF_LANES]);
    end
    lane_next = lane_sums;
    tail_next = tail_sum;
    if (do_fold) begin
      for (int j = 0; j < HALF_LANES; j++) begin
        lane_next[j]              = fold_sum[j];
        lane_next[j + HALF_LANES] = '0;
      end
    end
    if (do_acc) begin
      if (s3_route.to_tail) begin
        tail_next = acc_sum;
      end else begin
        lane_next[s3_route.lane] = acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || handoff) begin
      for (int j = 0; j < LANES; j++) begin
        lane_sums[j] <= '0;
      end
      tail_sum <= '0;
    end else if (s3_valid && commit) begin
      lane_sums <= lane_next;
      tail_sum  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || complete) begin
      phase <= 1'b0;
    end else if (s3_valid && two_step && !phase) begin
      phase <= 1'b1;
    end
  end

  // reduction unit: lanes left to right, then the tail
  assign red_last_k  = red_four ? (LANE_W+1)'(HALF_LANES) : (LANE_W+1)'(LANES);
  assign red_operand = (red_k == red_last_k) ? red_tail
                                             : red_lanes[red_k[LANE_W-1:0]];
  assign red_sum     = fp_add(red_acc, red_operand);
  assign out_free    = !out_valid || result.ready;
  assign red_done    = red_busy && (red_k == red_last_k) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_busy <= 1'b0;
    end else if (handoff) begin
      red_busy <= 1'b1;
    end else if (red_done) begin
      red_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      red_k     <= (LANE_W+1)'(1);
      red_acc   <= lane_next[0];
      red_lanes <= lane_next;
      red_tail  <= tail_next;
      red_four  <= block_mode;
    end else if (red_busy && red_k != red_last_k) begin
      red_k   <= red_k + (LANE_W+1)'(1);
      red_acc <= red_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (red_done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (red_done) begin
      out_data <= canon_nan(red_sum);
    end
  end

  assign result.valid         = out_valid;
  assign result.distance_bits = out_data;

endmodule

[hdl/sed_checker.sv]
// sed_checker: port-level assertions for squared_euclidean_distance
// bound to the top level below; depends on sed_pkg
module sed_checker import sed_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            dist_valid,
  input logic            dist_ready,
  input logic [FP_W-1:0] dist_bits
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    dist_valid && !dist_ready |=> dist_valid && $stable(dist_bits))
    else $error("stalled result changed");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !dist_valid)
    else $error("result valid after reset");

  // any nan result is the canonical quiet nan
  assert property (@(posedge clk) disable iff (rst)
    dist_valid && (dist_bits[30:23] == 8'hFF) && (dist_bits[22:0] != 23'd0)
    |-> dist_bits == QNAN)
    else $error("non-canonical nan result");

endmodule

bind squared_euclidean_distance sed_checker u_sed_checker (
  .clk        (clk),
  .rst        (rst),
  .dist_valid (result.valid),
  .dist_ready (result.ready),
  .dist_bits  (result.distance_bits)
);

[tb/sed_check.sv]
`timescale 1ns / 100ps
// sed_check: watches the cfg, elems and result channels of the distance block,
// predicts each distance in single-precision integer arithmetic and compares.
// Uses sed_pkg and the channel interfaces of sed_if.
module sed_check import sed_pkg::*; (
  input  logic clk,
  input  logic rst,
  sed_cfg_if   cfg,
  sed_elem_if  elems,
  sed_dist_if  result,
  output int   fails,
  output int   pending
);

  localparam logic [31:0] NAN_BITS = 32'h7FC0_0000;

  logic [31:0] lane_acc [LANES];
  logic [31:0] tail_acc;
  int          elem_idx;
  int          dim_reg;
  logic        four_mode;
  logic [31:0] distance_q [$];

  function automatic logic nan_of(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic logic inf_of(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction

  function automatic logic [63:0] sig_of(input logic [31:0] x);
    return x[30:23] == 0 ? {41'd0, x[22:0]} : {40'd0, 1'b1, x[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] x);
    return x[30:23] == 0 ? -149 : int'(x[30:23]) - 150;
  endfunction

  // value is m * 2^e, rounded to nearest even into single precision
  function automatic logic [31:0] round_single(input logic s, input logic [63:0] m,
                                               input int e);
    logic [24:0] mant;
    logic [2:0]  rb;
    int          fld;
    if (m == 0) return {s, 31'd0};
    while (m >= (64'd1 << 27)) begin
      m = (m >> 1) | (m & 64'd1);
      e++;
    end
    while (m < (64'd1 << 26) && e > -152) begin
      m = m << 1;
      e--;
    end
    while (e < -152) begin
      m = (m >> 1) | (m & 64'd1);
      e++;
    end
    mant = {1'b0, m[26:3]};
    rb   = m[2:0];
    if (rb > 3'd4 || (rb == 3'd4 && mant[0])) mant = mant + 1;
    e += 3;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
    end
    if (!mant[23]) return {s, 8'd0, mant[22:0]};
    fld = e + 150;
    if (fld >= 255) return {s, 8'hFF, 23'd0};
    return {s, fld[7:0], mant[22:0]};
  endfunction

  // significands sit at bit 62 at most, so the sum cannot carry out of 64 bits
  function automatic logic [31:0] single_add(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] t;
    logic [63:0] mx, my, ms, m;
    int          ex, ey, d;
    if (nan_of(x) || nan_of(y)) return NAN_BITS;
    if (inf_of(x) && inf_of(y)) return x[31] != y[31] ? NAN_BITS : x;
    if (inf_of(x)) return x;
    if (inf_of(y)) return y;
    if (exp_of(y) > exp_of(x)) begin
      t = x;
      x = y;
      y = t;
    end
    mx = sig_of(x) << 39;
    ex = exp_of(x) - 39;
    my = sig_of(y) << 39;
    ey = exp_of(y) - 39;
    d  = ex - ey;
    if (d >= 64) begin
      ms = {63'd0, my != 0};
    end else begin
      ms = my >> d;
      if ((my & ((64'd1 << d) - 1)) != 0) ms = ms | 64'd1;
    end
    if (x[31] == y[31]) return round_single(x[31], mx + ms, ex);
    if (mx == ms) return 32'd0;
    if (mx > ms) begin
      m = mx - ms;
      return round_single(x[31], m, ex);
    end
    m = ms - mx;
    return round_single(y[31], m, ex);
  endfunction

  function automatic logic [31:0] single_mul(input logic [31:0] x, input logic [31:0] y);
    logic s;
    logic xz, yz;
    s  = x[31] ^ y[31];
    xz = x[30:0] == 0;
    yz = y[30:0] == 0;
    if (nan_of(x) || nan_of(y)) return NAN_BITS;
    if ((inf_of(x) && yz) || (inf_of(y) && xz)) return NAN_BITS;
    if (inf_of(x) || inf_of(y)) return {s, 8'hFF, 23'd0};
    if (xz || yz) return {s, 31'd0};
    return round_single(s, sig_of(x) * sig_of(y), exp_of(x) + exp_of(y));
  endfunction

  task automatic clear_sums();
    for (int j = 0; j < LANES; j++) lane_acc[j] = 32'd0;
    tail_acc = 32'd0;
    elem_idx = 0;
  endtask

  task automatic fold_lanes();
    for (int j = 0; j < HALF_LANES; j++) begin
      lane_acc[j]              = single_add(lane_acc[j], lane_acc[j + HALF_LANES]);
      lane_acc[j + HALF_LANES] = 32'd0;
    end
  endtask

  task automatic accumulate_pair(input logic [31:0] a, input logic [31:0] b);
    int          d, q16, q4, n;
    logic [31:0] diff, sq, total;
    d    = dim_reg == 0 ? 1 : (dim_reg > MAX_DIM ? MAX_DIM : dim_reg);
    q16  = d & ~15;
    q4   = d & ~3;
    diff = single_add(a, {~b[31], b[30:0]});
    sq   = single_mul(diff, diff);
    if (four_mode && elem_idx == q16) fold_lanes();
    if (elem_idx < q16)
      lane_acc[elem_idx % LANES] = single_add(lane_acc[elem_idx % LANES], sq);
    else if (four_mode && elem_idx < q4)
      lane_acc[elem_idx % HALF_LANES] = single_add(lane_acc[elem_idx % HALF_LANES], sq);
    else
      tail_acc = single_add(tail_acc, sq);
    if (elem_idx + 1 < d) begin
      elem_idx++;
    end else begin
      if (four_mode && q16 == d) fold_lanes();
      n     = four_mode ? HALF_LANES : LANES;
      total = lane_acc[0];
      for (int j = 1; j < n; j++) total = single_add(total, lane_acc[j]);
      total = single_add(total, tail_acc);
      distance_q.push_back(nan_of(total) ? NAN_BITS : total);
      clear_sums();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;
  assign pending = distance_q.size();

  always @(posedge clk) begin
    if (rst) begin
      dim_reg   = 16;
      four_mode = 1'b0;
      clear_sums();
      distance_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_DIMENSION: begin
            dim_reg = int'(cfg.data);
            clear_sums();
          end
          CFG_BLOCK_MODE: begin
            four_mode = cfg.data[0];
            clear_sums();
          end
          default: ;
        endcase
      end
      if (elems.valid && elems.ready) accumulate_pair(elems.elem_a, elems.elem_b);
      if (result.valid && result.ready) begin
        if (distance_q.size() == 0) begin
          report("unexpected distance", result.distance_bits, 32'd0);
        end else begin
          if (result.distance_bits !== distance_q[0])
            report("distance_bits", result.distance_bits, distance_q[0]);
          void'(distance_q.pop_front());
        end
      end
    end
  end

endmodule

[tb/squared_euclidean_distance_test.sv]
`timescale 1ns / 100ps
// squared_euclidean_distance_test: stimulus and verdict for the distance block:
// directed corner pairs, then random vectors over several register settings.
// Uses sed_pkg, sed_if, the block and the sed_check checker.
module squared_euclidean_distance_test import sed_pkg::*; ;

  localparam int LIMIT = 500000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   cycles;
  logic hold_req;
  logic hold_done;
  int   hold_cnt;
  int   ready_gap;
  int   calm_cnt;
  int   k;

  sed_cfg_if  cfg ();
  sed_elem_if elems ();
  sed_dist_if result ();

  squared_euclidean_distance u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .elems  (elems),
    .result (result)
  );

  sed_check u_check (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .elems   (elems),
    .result  (result),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side: random stalls, calm stretches and one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt  = 400;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      result.ready <= 1'b0;
    end else if (calm_cnt > 0) begin
      calm_cnt--;
      result.ready <= 1'b1;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        result.ready <= 1'b1;
      end else if (k < 63) begin
        calm_cnt = $urandom_range(50, 200);
        result.ready <= 1'b1;
      end else if (k < 92) begin
        ready_gap = $urandom_range(0, 3);
        result.ready <= 1'b0;
      end else begin
        ready_gap = $urandom_range(5, 30);
        result.ready <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] pick_float();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) return {1'($urandom), 8'($urandom_range(117, 137)), 23'($urandom)};
    if (n < 68) return $urandom;
    if (n < 76) return {1'($urandom), 8'd0, 23'($urandom)};
    if (n < 82) return {1'($urandom), 8'($urandom_range(1, 12)), 23'($urandom)};
    if (n < 87) return {1'($urandom), 8'($urandom_range(190, 254)), 23'($urandom)};
    if (n < 92) return {1'($urandom), 31'd0};
    if (n < 95) return {1'($urandom), 8'hFF, 23'd0};
    if (n < 97) return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))};
    return {1'($urandom), 31'h7F7F_FFFF};
  endfunction

  function automatic int pick_gap(input logic calm);
    int n;
    if (calm) return 0;
    n = $urandom_range(0, 99);
    if (n < 60) return 0;
    if (n < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input int gap);
    elems.valid  <= 1'b1;
    elems.elem_a <= a;
    elems.elem_b <= b;
    @(posedge clk);
    while (!elems.ready) @(posedge clk);
    if (gap > 0) begin
      elems.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle_and_configure(input int dimension, input logic mode);
    elems.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(CFG_DIMENSION, CFG_DATA_W'(dimension));
    write_reg(CFG_BLOCK_MODE, CFG_DATA_W'(mode));
  endtask

  logic [31:0] corner_a [16] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F7F_FFFF,
    32'h7F80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
    32'h0000_0001, 32'h0080_0000, 32'h1F80_0000, 32'hFFFF_FFFF,
    32'h0000_0003, 32'h4049_0FDB, 32'h7F7F_FFFF, 32'hAAAA_AAAA
  };
  logic [31:0] corner_b [16] = '{
    32'h0000_0000, 32'h0000_0000, 32'hBF80_0000, 32'hFF7F_FFFF,
    32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000,
    32'h8000_0001, 32'h007F_FFFF, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0001, 32'hC049_0FDB, 32'h7F7F_FFFE, 32'h5555_5555
  };

  int          dims  [14] = '{16, 1, 17, 0, 3, 4, 20, 37, 2047, 100, 64, 5, 33, 2};
  logic        modes [14] = '{1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1, 0, 0, 1};
  int          eff, nvec, npair;
  logic        calm;
  logic [31:0] a, b;

  initial begin
    cycles       = 0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    hold_cnt     = 0;
    ready_gap    = 0;
    calm_cnt     = 0;
    rst          = 1'b1;
    cfg.valid    = 1'b0;
    cfg.index    = CFG_DIMENSION;
    cfg.data     = '0;
    elems.valid  = 1'b0;
    elems.elem_a = '0;
    elems.elem_b = '0;
    result.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default setting first, then corners one per vector
    for (int v = 0; v < 2; v++)
      for (int i = 0; i < 16; i++) send_pair(pick_float(), pick_float(), pick_gap(1'b0));
    settle_and_configure(1, 1'b0);
    for (int i = 0; i < 16; i++) send_pair(corner_a[i], corner_b[i], pick_gap(1'b0));

    // a very long dimension gets a partial vector that the next write abandons
    for (int p = 0; p < 14; p++) begin
      settle_and_configure(dims[p], modes[p]);
      eff   = dims[p] == 0 ? 1 : (dims[p] > MAX_DIM ? MAX_DIM : dims[p]);
      npair = eff > 200 ? 25 : eff;
      nvec  = eff >= 20 ? 1 : 20 / eff;
      calm  = $urandom_range(0, 3) == 0;
      for (int v = 0; v < nvec; v++)
        for (int i = 0; i < npair; i++) begin
          a = pick_float();
          b = $urandom_range(0, 9) == 0 ? a : pick_float();
          send_pair(a, b, pick_gap(calm));
        end
    end

    // long hold-off on result while short vectors keep coming
    settle_and_configure(1, 1'b0);
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_pair(pick_float(), pick_float(), 0);

    elems.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
